// ===== rtl/core/ofdm_ls_channel_estimator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the OFDM LS channel estimator
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef OFDM_LS_CHANNEL_ESTIMATOR_UNIT_ASSERT_SVH
`define OFDM_LS_CHANNEL_ESTIMATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define OLCE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define OLCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define OLCE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define OLCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/olce_pkg.sv =====
// ----------------------------------------------------------------------------
// olce_pkg
// Shared constants, types and helpers of the OFDM LS channel estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olce_pkg;

  localparam int VLEN_DEF       = 64;
  localparam int MAX_BLOCKS_DEF = 8;

  localparam int QW = 16;             // quotient bits
  localparam int DW = 32;             // divisor bits
  localparam int WW = DW + QW;        // divider working width

  localparam logic [31:0] RX_THR_RST    = 32'd6711;
  localparam logic [31:0] KNOWN_THR_RST = 32'd0;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  localparam logic REG_RX_THR    = 1'b0;
  localparam logic REG_KNOWN_THR = 1'b1;

  localparam logic [15:0] ONE_Q510 = 16'd1024;

  typedef struct packed {
    logic       v;
    logic       ok;
    logic       known;
    logic       pilot;
    logic       last;
    logic [3:0] neg;
  } ctl_t;

  // quotient magnitude to signed Q5.10 with saturation
  function automatic logic [15:0] sat_q(input logic [15:0] q, input logic ovf,
                                        input logic neg);
    logic [15:0] r;
    if (!neg) begin
      r = (ovf || q[15]) ? 16'h7FFF : q;
    end else begin
      r = (ovf || (q > 16'h8000)) ? 16'h8000 : (16'd0 - q);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/olce_ram.sv =====
// ----------------------------------------------------------------------------
// olce_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olce_ram #(
  parameter int W = 32,
  parameter int D = 512
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [0:D-1];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/olce_div_pipe.sv =====
// ----------------------------------------------------------------------------
// olce_div_pipe
// Pipelined restoring divider: overflow check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olce_div_pipe (
  input  logic                      clk,
  input  logic                      en,
  input  logic [olce_pkg::WW-1:0]   n_i,
  input  logic [olce_pkg::DW-1:0]   d_i,
  output logic [olce_pkg::QW-1:0]   q_o,
  output logic                      ovf_o
);

  localparam int QW = olce_pkg::QW;
  localparam int DW = olce_pkg::DW;
  localparam int WW = olce_pkg::WW;

  logic [WW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] quo_r [0:QW];
  logic          ovf_r [0:QW];

  // quotient would need more than QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_i;
      den_r[0] <= d_i;
      quo_r[0] <= '0;
      ovf_r[0] <= (n_i >= {d_i, {QW{1'b0}}});
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [WW-1:0] sh;
    logic          take;
    assign sh   = {{QW{1'b0}}, den_r[j-1]} << (QW - j);
    assign take = (rem_r[j-1] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take ? (rem_r[j-1] - sh) : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        quo_r[j] <= quo_r[j-1] | (take ? (QW'(1) << (QW - j)) : '0);
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign q_o   = quo_r[QW];
  assign ovf_o = ovf_r[QW];

endmodule

// ===== rtl/core/ofdm_ls_channel_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// ofdm_ls_channel_estimator_unit
// Least-squares channel estimate per subcarrier with pilot hold and reuse.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake       Content
// in_*      in   tvalid/tready   sample or known-symbol load, kind in tuser
// out_*     out  tvalid/tready   inverse and transfer estimate, tlast
// cfg_*     in   APB write/read  rx_power_threshold, known_mag_threshold
//
// One item per clock while the output is free or taken. A sample passes, in
// order, 1 symbol-RAM read, products, sums, dividend forming, 17 divider
// stages and the output register. Load items produce no result.
// All stages move together on one advance signal (output free or taken), so
// a stall freezes the whole pipe without loss. Reset is synchronous; the held
// estimate store uses per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofdm_ls_channel_estimator_unit #(
  parameter int VLEN       = olce_pkg::VLEN_DEF,
  parameter int MAX_BLOCKS = olce_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: value_re[15:0], value_im[31:16], block_number[34:32],
  //        sub_index[40:35], pilot_flag[41], zero fill [47:42]
  input  logic [47:0] in_tdata,
  // tuser: kind[0], frame_start[1]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: inv_re[15:0], inv_im[31:16], ctf_re[47:32], ctf_im[63:48]
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PW      = $clog2(VLEN);
  localparam int BCW     = $clog2(MAX_BLOCKS + 1);
  localparam int BIW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int KD      = MAX_BLOCKS * VLEN;
  localparam int KAW     = $clog2(KD);
  localparam int DIV_LAT = olce_pkg::QW + 1;
  localparam int WW      = olce_pkg::WW;

  localparam logic [63:0] HELD_RST = {16'd0, olce_pkg::ONE_Q510,
                                      16'd0, olce_pkg::ONE_Q510};

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] rx_thr_r, known_thr_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_thr_r    <= olce_pkg::RX_THR_RST;
      known_thr_r <= olce_pkg::KNOWN_THR_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        olce_pkg::REG_RX_THR:    rx_thr_r    <= cfg_pwdata;
        olce_pkg::REG_KNOWN_THR: known_thr_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      olce_pkg::REG_RX_THR:    cfg_prdata = rx_thr_r;
      olce_pkg::REG_KNOWN_THR: cfg_prdata = known_thr_r;
      default:                 cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // global advance: every stage moves when output is taken or the output register is free
  // --------------------------------------------------------------------------
  logic out_v_r;
  logic adv, in_acc;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // --------------------------------------------------------------------------
  // front end: frame/block bookkeeping, known-symbol store
  // --------------------------------------------------------------------------
  logic                  kind, fstart, pflag;
  logic [2:0]            blk;
  logic [5:0]            sub;
  logic signed [15:0]    v_re, v_im;
  logic                  ld_ok, ld_we;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [BCW-1:0]        bc_r, bc_nxt, bc_use, fl_r, fl_nxt;
  logic [MAX_BLOCKS-1:0] known_r, known_nxt, pilot_r, pilot_nxt;
  logic [BIW-1:0]        bidx, lidx;
  logic                  bc_in, s_known, s_pilot, s_last;
  logic [31:0]           blk1;
  logic [KAW-1:0]        k_waddr, k_raddr;
  logic [31:0]           k_rdata;

  assign kind   = in_tuser[0];
  assign fstart = in_tuser[1];
  assign v_re   = in_tdata[15:0];
  assign v_im   = in_tdata[31:16];
  assign blk    = in_tdata[34:32];
  assign sub    = in_tdata[40:35];
  assign pflag  = in_tdata[41];

  assign ld_ok = (32'(blk) < 32'(MAX_BLOCKS)) && (32'(sub) < 32'(VLEN));
  assign ld_we = in_acc && (kind == olce_pkg::KIND_LOAD) && ld_ok;
  assign blk1  = 32'(blk) + 32'd1;
  assign lidx  = BIW'(blk);

  // frame trigger only counts on the first subcarrier of a vector
  assign bc_use  = (pos_r == '0 && fstart) ? '0 : bc_r;
  assign bc_in   = bc_use < BCW'(MAX_BLOCKS);
  assign bidx    = bc_use[BIW-1:0];
  assign s_known = (bc_use < fl_r) && bc_in && known_r[bidx];
  assign s_pilot = pilot_r[bidx];
  assign s_last  = (pos_r == PW'(VLEN - 1));

  always_comb begin
    pos_nxt   = pos_r;
    bc_nxt    = bc_r;
    fl_nxt    = fl_r;
    known_nxt = known_r;
    pilot_nxt = pilot_r;
    if (in_acc) begin
      if (kind == olce_pkg::KIND_LOAD) begin
        if (ld_ok) begin
          known_nxt[lidx] = 1'b1;
          pilot_nxt[lidx] = pflag;
          fl_nxt  = (blk1 > 32'(fl_r)) ? BCW'(blk1) : fl_r;
          bc_nxt  = fl_nxt;
          pos_nxt = '0;
        end
      end else if (s_last) begin
        pos_nxt = '0;
        bc_nxt  = bc_in ? (bc_use + BCW'(1)) : bc_use;
      end else begin
        pos_nxt = pos_r + PW'(1);
        bc_nxt  = bc_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      bc_r    <= '0;
      fl_r    <= '0;
      known_r <= '0;
      pilot_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      bc_r    <= bc_nxt;
      fl_r    <= fl_nxt;
      known_r <= known_nxt;
      pilot_r <= pilot_nxt;
    end
  end

  assign k_waddr = KAW'(lidx) * KAW'(VLEN) + KAW'(sub);
  assign k_raddr = KAW'(bidx) * KAW'(VLEN) + KAW'(pos_r);

  olce_ram #(.W(32), .D(KD)) u_known_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (k_waddr),
    .wdata ({v_im, v_re}),
    .re    (in_acc && (kind == olce_pkg::KIND_SAMPLE)),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: sample and control, known symbol from RAM
  // --------------------------------------------------------------------------
  olce_pkg::ctl_t     c1_r, c2_r, c3_r, c4_r;
  logic [PW-1:0]      p1_r, p2_r, p3_r, p4_r;
  logic signed [15:0] br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.v <= 1'b0;
    end else if (adv) begin
      c1_r.v     <= in_acc && (kind == olce_pkg::KIND_SAMPLE);
      c1_r.ok    <= 1'b0;
      c1_r.known <= s_known;
      c1_r.pilot <= s_pilot;
      c1_r.last  <= s_last;
      c1_r.neg   <= '0;
      p1_r       <= pos_r;
      br1_r      <= v_re;
      bi1_r      <= v_im;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: products
  // --------------------------------------------------------------------------
  logic signed [15:0] kr, ki;
  logic signed [31:0] krbr_r, kibi_r, kibr_r, krbi_r, krkr_r, kiki_r, brbr_r, bibi_r;

  assign kr = k_rdata[15:0];
  assign ki = k_rdata[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.v <= 1'b0;
    end else if (adv) begin
      c2_r   <= c1_r;
      p2_r   <= p1_r;
      krbr_r <= kr * br1_r;
      kibi_r <= ki * bi1_r;
      kibr_r <= ki * br1_r;
      krbi_r <= kr * bi1_r;
      krkr_r <= kr * kr;
      kiki_r <= ki * ki;
      brbr_r <= br1_r * br1_r;
      bibi_r <= bi1_r * bi1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: powers, cross terms, threshold tests
  // --------------------------------------------------------------------------
  logic signed [32:0] kp_s, bp_s, sre_s, sim_s;
  logic signed [32:0] sre3_r, sim3_r;
  logic [31:0]        kp3_r, bp3_r;

  assign kp_s  = 33'(krkr_r) + 33'(kiki_r);
  assign bp_s  = 33'(brbr_r) + 33'(bibi_r);
  assign sre_s = 33'(krbr_r) + 33'(kibi_r);
  assign sim_s = 33'(kibr_r) - 33'(krbi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r.v <= 1'b0;
    end else if (adv) begin
      c3_r.v     <= c2_r.v;
      c3_r.ok    <= (kp_s[31:0] > known_thr_r) && (bp_s[31:0] > rx_thr_r);
      c3_r.known <= c2_r.known;
      c3_r.pilot <= c2_r.pilot;
      c3_r.last  <= c2_r.last;
      c3_r.neg   <= '0;
      p3_r       <= p2_r;
      kp3_r      <= kp_s[31:0];
      bp3_r      <= bp_s[31:0];
      sre3_r     <= sre_s;
      sim3_r     <= sim_s;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: dividends |num|*1024 + den/2, signs
  // --------------------------------------------------------------------------
  logic signed [32:0] sre_abs, sim_abs;
  logic [WW-1:0]      n_inv_re_r, n_inv_im_r, n_ctf_re_r, n_ctf_im_r;
  logic [31:0]        kp4_r, bp4_r;
  logic               sim_pos;

  assign sre_abs = sre3_r[32] ? -sre3_r : sre3_r;
  assign sim_abs = sim3_r[32] ? -sim3_r : sim3_r;
  assign sim_pos = !sim3_r[32] && (sim3_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r.v <= 1'b0;
    end else if (adv) begin
      c4_r.v     <= c3_r.v;
      c4_r.ok    <= c3_r.ok;
      c4_r.known <= c3_r.known;
      c4_r.pilot <= c3_r.pilot;
      c4_r.last  <= c3_r.last;
      // order: inv_re, inv_im, ctf_re, ctf_im; ctf_im numerator is -sim
      c4_r.neg   <= {sim_pos, sre3_r[32], sim3_r[32], sre3_r[32]};
      p4_r       <= p3_r;
      kp4_r      <= kp3_r;
      bp4_r      <= bp3_r;
      n_inv_re_r <= WW'({sre_abs[31:0], 10'b0}) + WW'(bp3_r[31:1]);
      n_inv_im_r <= WW'({sim_abs[31:0], 10'b0}) + WW'(bp3_r[31:1]);
      n_ctf_re_r <= WW'({sre_abs[31:0], 10'b0}) + WW'(kp3_r[31:1]);
      n_ctf_im_r <= WW'({sim_abs[31:0], 10'b0}) + WW'(kp3_r[31:1]);
    end
  end

  // --------------------------------------------------------------------------
  // dividers, control travels alongside
  // --------------------------------------------------------------------------
  logic [15:0] q_inv_re, q_inv_im, q_ctf_re, q_ctf_im;
  logic        o_inv_re, o_inv_im, o_ctf_re, o_ctf_im;

  olce_div_pipe u_div_inv_re (.clk(clk), .en(adv), .n_i(n_inv_re_r), .d_i(bp4_r),
                              .q_o(q_inv_re), .ovf_o(o_inv_re));
  olce_div_pipe u_div_inv_im (.clk(clk), .en(adv), .n_i(n_inv_im_r), .d_i(bp4_r),
                              .q_o(q_inv_im), .ovf_o(o_inv_im));
  olce_div_pipe u_div_ctf_re (.clk(clk), .en(adv), .n_i(n_ctf_re_r), .d_i(kp4_r),
                              .q_o(q_ctf_re), .ovf_o(o_ctf_re));
  olce_div_pipe u_div_ctf_im (.clk(clk), .en(adv), .n_i(n_ctf_im_r), .d_i(kp4_r),
                              .q_o(q_ctf_im), .ovf_o(o_ctf_im));

  olce_pkg::ctl_t ctl_r [0:DIV_LAT-1];
  logic [PW-1:0]  pd_r  [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        ctl_r[i].v <= 1'b0;
      end
    end else if (adv) begin
      ctl_r[0] <= c4_r;
      pd_r[0]  <= p4_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
        pd_r[i]  <= pd_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // final stage: saturation, held-estimate store (read and write in order)
  // --------------------------------------------------------------------------
  olce_pkg::ctl_t cf;
  logic [PW-1:0]  pf, pr;
  logic [63:0]    est, held_rd, held_val, res;
  logic           h_we;
  logic [VLEN-1:0] hval_r;
  logic           hv_r, byp_r;
  logic [63:0]    byp_d_r;
  logic [63:0]    out_d_r;
  logic           out_last_r;

  assign cf = ctl_r[DIV_LAT-1];
  assign pf = pd_r[DIV_LAT-1];
  assign pr = pd_r[DIV_LAT-2];

  always_comb begin
    est = '0;
    if (cf.ok) begin
      est = {olce_pkg::sat_q(q_ctf_im, o_ctf_im, cf.neg[3]),
             olce_pkg::sat_q(q_ctf_re, o_ctf_re, cf.neg[2]),
             olce_pkg::sat_q(q_inv_im, o_inv_im, cf.neg[1]),
             olce_pkg::sat_q(q_inv_re, o_inv_re, cf.neg[0])};
    end
  end

  assign h_we = adv && cf.v && cf.known && cf.pilot;

  olce_ram #(.W(64), .D(VLEN)) u_held_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (pf),
    .wdata (est),
    .re    (adv),
    .raddr (pr),
    .rdata (held_rd)
  );

  // a write and a read of the same entry on one edge: forward the new value
  always_ff @(posedge clk) begin
    if (adv) begin
      byp_r   <= h_we && (pf == pr);
      byp_d_r <= est;
      hv_r    <= hval_r[pr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hval_r <= '0;
    end else if (h_we) begin
      hval_r[pf] <= 1'b1;
    end
  end

  assign held_val = byp_r ? byp_d_r : (hv_r ? held_rd : HELD_RST);
  assign res      = cf.known ? est : held_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= cf.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r    <= res;
      out_last_r <= cf.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  logic cnt_ok, tail_mv;

  assign cnt_ok  = (bc_r <= BCW'(MAX_BLOCKS)) && (fl_r <= BCW'(MAX_BLOCKS));
  assign tail_mv = adv && cf.v;

`include "ofdm_ls_channel_estimator_unit_assert.svh"

  `OLCE_ASSERT_NEXT(a_load_rewinds, clk, rst_n, ld_we, pos_r == '0, "load kept position")
  `OLCE_ASSERT_SAME(a_bc_range, clk, rst_n, 1'b1, cnt_ok, "block count out of range")
  `OLCE_ASSERT_NEXT(a_tail_to_out, clk, rst_n, tail_mv, out_tvalid, "item lost before output")

endmodule
